// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("property violated");

// Condition that must never hold out of reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== rtl/core/ucee_pkg.sv =====
// Shared types, codes and descriptor table of the endpoint-0 control engine.
package ucee_pkg;

    localparam int MAX_PACKET          = 64;
    localparam int DESCRIPTOR_COUNT    = 5;
    localparam int TABLE_SIZE          = 5;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [6:0] CHUNK_BYTES = 7'(MAX_PACKET);

    // event codes
    localparam logic [2:0] CMD_SETUP     = 3'd0;
    localparam logic [2:0] CMD_IN        = 3'd1;
    localparam logic [2:0] CMD_OUT       = 3'd2;
    localparam logic [2:0] CMD_SOF       = 3'd3;
    localparam logic [2:0] CMD_BUS_RESET = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_TRANSMIT = 3'd1;
    localparam logic [2:0] KIND_STALL    = 3'd2;
    localparam logic [2:0] KIND_SET_ADDR = 3'd3;
    localparam logic [2:0] KIND_REARM    = 3'd4;

    // setup requests (request in high byte, type in low byte)
    localparam logic [15:0] REQ_SET_ADDRESS  = 16'h0500;
    localparam logic [15:0] REQ_SET_CONFIG   = 16'h0900;
    localparam logic [15:0] REQ_GET_DESC_DEV = 16'h0680;
    localparam logic [15:0] REQ_GET_DESC_IF  = 16'h0681;

    localparam logic [15:0] LANG_EN_US = 16'h0409;

    // device, configuration, language, manufacturer, product
    localparam logic [15:0] KEY_VALUE [TABLE_SIZE] =
        '{16'h0100, 16'h0200, 16'h0300, 16'h0301, 16'h0302};
    localparam logic [15:0] KEY_INDEX [TABLE_SIZE] =
        '{16'h0000, 16'h0000, 16'h0000, LANG_EN_US, LANG_EN_US};
    localparam logic [7:0] KEY_LENGTH [TABLE_SIZE] =
        '{8'd18, 8'd25, 8'd4, 8'd32, 8'd32};

    // decoded event, front to back
    typedef struct packed {
        logic [2:0] cmd;
        logic       bank;
        logic       stall;
        logic [2:0] sel;
        logic [7:0] len;
        logic       set_address;
        logic [6:0] address;
    } op_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       bank_odd;
        logic [6:0] byte_count;
        logic       data1;
        logic [2:0] descriptor_select;
        logic [7:0] byte_offset;
        logic [6:0] device_address;
        logic       last;
    } result_t;

endpackage

// ===== rtl/core/ucee_front.sv =====
// Event decode: request classification, descriptor lookup and length clamp.
module ucee_front import ucee_pkg::*;
(
    input  logic [2:0]  cmd,
    input  logic        odd_bank,
    input  logic [15:0] request_code,
    input  logic [15:0] request_value,
    input  logic [15:0] request_index,
    input  logic [15:0] request_length,
    output op_t         op,
    output logic        keep
);

    logic       hit;
    logic [2:0] hit_sel;
    logic [7:0] hit_len;
    logic       is_status;
    logic       is_get;

    always_comb
    begin
        hit     = 1'b0;
        hit_sel = '0;
        hit_len = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (!hit && i < DESCRIPTOR_COUNT &&
                KEY_VALUE[i] == request_value && KEY_INDEX[i] == request_index)
            begin
                hit     = 1'b1;
                hit_sel = 3'(i);
                hit_len = KEY_LENGTH[i];
            end
        end
    end

    assign is_status = (request_code == REQ_SET_ADDRESS) || (request_code == REQ_SET_CONFIG);
    assign is_get    = (request_code == REQ_GET_DESC_DEV) || (request_code == REQ_GET_DESC_IF);

    always_comb
    begin
        op.cmd         = cmd;
        op.bank        = odd_bank;
        op.set_address = (request_code == REQ_SET_ADDRESS);
        op.address     = request_value[6:0];
        op.stall       = 1'b0;
        op.sel         = '0;
        op.len         = '0;
        if (is_status)
        begin
            // zero-length status packet
            op.stall = 1'b0;
        end
        else if (is_get && hit)
        begin
            op.sel = hit_sel;
            op.len = ({8'd0, hit_len} > request_length) ? request_length[7:0] : hit_len;
        end
        else
        begin
            op.stall = 1'b1;
        end
    end

    // start of frame and unused codes leave no trace
    assign keep = cmd inside {CMD_SETUP, CMD_IN, CMD_OUT, CMD_BUS_RESET};

endmodule

// ===== rtl/core/ucee_queue.sv =====
// Small register queue of decoded events between front and back.
module ucee_queue import ucee_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head_op,
    output logic head_valid,
    output logic full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head_op    = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));

endmodule

// ===== rtl/core/ucee_back.sv =====
// Result sequencer: endpoint state, chunking and the output register.
module ucee_back import ucee_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    op_valid,
    input  op_t     op,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    localparam logic [1:0] STEP_FIRST  = 2'd0;
    localparam logic [1:0] STEP_SECOND = 2'd1;

    logic       tx_odd_reg, tx_odd_next;
    logic       tx_toggle_reg, tx_toggle_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [2:0] pend_sel_reg, pend_sel_next;
    logic [7:0] pend_off_reg, pend_off_next;
    logic [7:0] pend_rem_reg, pend_rem_next;
    logic       lwsa_reg, lwsa_next;
    logic [6:0] saved_addr_reg, saved_addr_next;
    logic [1:0] step_reg, step_next;
    logic       out_valid_reg;
    result_t    out_reg;

    result_t    res;
    logic       res_en;
    logic       done;
    logic       fire;
    logic       load_ok;
    logic [7:0] src_len;
    logic [6:0] size;
    logic [7:0] rem_after;
    logic       short_end;

    // chunk sizing: first data chunk of a setup comes from the op, the rest from pending
    assign src_len   = (op.cmd == CMD_SETUP && step_reg == STEP_SECOND) ? op.len : pend_rem_reg;
    assign size      = (src_len > {1'b0, CHUNK_BYTES}) ? CHUNK_BYTES : src_len[6:0];
    assign rem_after = src_len - {1'b0, size};
    assign short_end = (rem_after == '0) && (size != CHUNK_BYTES);

    always_comb
    begin
        tx_odd_next     = tx_odd_reg;
        tx_toggle_next  = tx_toggle_reg;
        pend_valid_next = pend_valid_reg;
        pend_sel_next   = pend_sel_reg;
        pend_off_next   = pend_off_reg;
        pend_rem_next   = pend_rem_reg;
        lwsa_next       = lwsa_reg;
        saved_addr_next = saved_addr_reg;
        res             = '0;
        res_en          = 1'b0;
        done            = 1'b0;

        case (op.cmd)
            CMD_SETUP:
            begin
                res_en = 1'b1;
                case (step_reg)
                    STEP_FIRST:
                    begin
                        res.kind        = KIND_REARM;
                        res.bank_odd    = op.bank;
                        res.byte_count  = CHUNK_BYTES;
                        res.data1       = 1'b1;
                        pend_valid_next = 1'b0;
                        pend_sel_next   = '0;
                        pend_off_next   = '0;
                        pend_rem_next   = '0;
                        tx_toggle_next  = 1'b1;
                        lwsa_next       = op.set_address;
                        saved_addr_next = op.address;
                    end
                    STEP_SECOND:
                    begin
                        if (op.stall)
                        begin
                            res.kind = KIND_STALL;
                            done     = 1'b1;
                        end
                        else
                        begin
                            res.kind              = KIND_TRANSMIT;
                            res.bank_odd          = tx_odd_reg;
                            res.byte_count        = size;
                            res.data1             = tx_toggle_reg;
                            res.descriptor_select = op.sel;
                            tx_odd_next           = !tx_odd_reg;
                            tx_toggle_next        = !tx_toggle_reg;
                            pend_sel_next         = op.sel;
                            pend_off_next         = {1'b0, size};
                            pend_rem_next         = rem_after;
                            done                  = short_end;
                        end
                    end
                    default:
                    begin
                        res.kind              = KIND_TRANSMIT;
                        res.bank_odd          = tx_odd_reg;
                        res.byte_count        = size;
                        res.data1             = tx_toggle_reg;
                        res.descriptor_select = pend_sel_reg;
                        res.byte_offset       = pend_off_reg;
                        tx_odd_next           = !tx_odd_reg;
                        tx_toggle_next        = !tx_toggle_reg;
                        pend_off_next         = pend_off_reg + {1'b0, size};
                        pend_rem_next         = rem_after;
                        pend_valid_next       = !short_end;
                        done                  = 1'b1;
                    end
                endcase
            end
            CMD_IN:
            begin
                if (step_reg == STEP_FIRST && pend_valid_reg)
                begin
                    res_en                = 1'b1;
                    res.kind              = KIND_TRANSMIT;
                    res.bank_odd          = tx_odd_reg;
                    res.byte_count        = size;
                    res.data1             = tx_toggle_reg;
                    res.descriptor_select = pend_sel_reg;
                    res.byte_offset       = pend_off_reg;
                    tx_odd_next           = !tx_odd_reg;
                    tx_toggle_next        = !tx_toggle_reg;
                    pend_off_next         = pend_off_reg + {1'b0, size};
                    pend_rem_next         = rem_after;
                    pend_valid_next       = (rem_after != '0) || (size == CHUNK_BYTES);
                    done                  = !lwsa_reg;
                end
                else if (lwsa_reg)
                begin
                    res_en             = 1'b1;
                    res.kind           = KIND_SET_ADDR;
                    res.device_address = saved_addr_reg;
                    done               = 1'b1;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            CMD_OUT:
            begin
                res_en         = 1'b1;
                res.kind       = KIND_REARM;
                res.bank_odd   = op.bank;
                res.byte_count = CHUNK_BYTES;
                res.data1      = 1'b1;
                done           = 1'b1;
            end
            CMD_BUS_RESET:
            begin
                res_en = 1'b1;
                case (step_reg)
                    STEP_FIRST:
                    begin
                        res.kind        = KIND_REARM;
                        res.byte_count  = CHUNK_BYTES;
                        tx_odd_next     = 1'b0;
                        pend_valid_next = 1'b0;
                        pend_sel_next   = '0;
                        pend_off_next   = '0;
                        pend_rem_next   = '0;
                        lwsa_next       = 1'b0;
                    end
                    STEP_SECOND:
                    begin
                        res.kind       = KIND_REARM;
                        res.bank_odd   = 1'b1;
                        res.byte_count = CHUNK_BYTES;
                    end
                    default:
                    begin
                        res.kind = KIND_SET_ADDR;
                        done     = 1'b1;
                    end
                endcase
            end
            default:
            begin
                done = 1'b1;
            end
        endcase

        res.last = done;
    end

    assign load_ok   = !out_valid_reg || out_ready;
    assign fire      = op_valid && (!res_en || load_ok);
    assign pop       = fire && done;
    assign step_next = done ? STEP_FIRST : step_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_odd_reg     <= 1'b0;
            tx_toggle_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_sel_reg   <= '0;
            pend_off_reg   <= '0;
            pend_rem_reg   <= '0;
            lwsa_reg       <= 1'b0;
            saved_addr_reg <= '0;
            step_reg       <= STEP_FIRST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                tx_odd_reg     <= tx_odd_next;
                tx_toggle_reg  <= tx_toggle_next;
                pend_valid_reg <= pend_valid_next;
                pend_sel_reg   <= pend_sel_next;
                pend_off_reg   <= pend_off_next;
                pend_rem_reg   <= pend_rem_next;
                lwsa_reg       <= lwsa_next;
                saved_addr_reg <= saved_addr_next;
                step_reg       <= step_next;
            end
            if (fire && res_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_en)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

// ===== rtl/core/usb_control_endpoint_engine.sv =====
// Top level of the endpoint-0 control transfer engine.
// Each accepted event beat is decoded in the cycle it arrives (request class,
// descriptor lookup, length clamp) and written into a QUEUE_DEPTH-entry queue;
// start-of-frame and unused event codes are dropped there. The back end takes
// one event from the queue at a time and produces one result beat per cycle
// into an output register while that register is free or being taken; an event
// yields one to three results, or none for an in event with nothing to send.
// Input stays open while the queue has room, also while a result waits on the
// output; the back end's one-result-per-cycle sequencer sets the sustained rate.
`include "assert_macros.svh"

module usb_control_endpoint_engine import ucee_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // odd_bank, request_code, request_value, request_index,
                                   // request_length, zero fill
    input  logic [2:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // bank_odd, byte_count, data1, descriptor_select,
                                   // byte_offset, device_address, zero fill
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast    // last
);

    op_t     dec_op;
    logic    dec_keep;
    op_t     head_op;
    logic    head_valid;
    logic    q_full;
    logic    q_pop;
    result_t res;

    ucee_front u_front
    (
        .cmd            (s_tuser),
        .odd_bank       (s_tdata[0]),
        .request_code   (s_tdata[16:1]),
        .request_value  (s_tdata[32:17]),
        .request_index  (s_tdata[48:33]),
        .request_length (s_tdata[64:49]),
        .op             (dec_op),
        .keep           (dec_keep)
    );

    ucee_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid && s_tready && dec_keep),
        .push_op    (dec_op),
        .pop        (q_pop),
        .head_op    (head_op),
        .head_valid (head_valid),
        .full       (q_full)
    );

    ucee_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (head_valid),
        .op         (head_op),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    assign s_tready = !q_full;

    assign m_tuser = res.kind;
    assign m_tlast = res.last;
    assign m_tdata = {5'd0, res.device_address, res.byte_offset, res.descriptor_select,
                      res.data1, res.byte_count, res.bank_odd};

    // a stall always closes its event
    `ASSERT_IMPLIES(a_stall_is_last, clk, rst_n, m_tvalid && m_tuser == KIND_STALL, m_tlast)
    // receive banks are always armed for a full packet
    `ASSERT_IMPLIES(a_rearm_full, clk, rst_n, m_tvalid && m_tuser == KIND_REARM,
                    m_tdata[7:1] == CHUNK_BYTES)
    // no chunk larger than a packet
    `ASSERT_NEVER(a_chunk_size, clk, rst_n,
                  m_tvalid && m_tuser == KIND_TRANSMIT && m_tdata[7:1] > CHUNK_BYTES)
    // kind nothing is never sent
    `ASSERT_NEVER(a_no_empty_kind, clk, rst_n, m_tvalid && m_tuser == KIND_NONE)

endmodule

// ===== verif/usb_control_endpoint_engine_tb.sv =====
// Self-checking testbench for the endpoint-0 control transfer engine.
module usb_control_endpoint_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ucee_pkg::*;

    localparam int          RANDOM_EVENTS   = 360;
    localparam int          QUIET_FROM      = 300;
    localparam int          DESC_ENTRIES    = 5;
    localparam logic [2:0]  CMD_RESERVED_LO = 3'd5;
    localparam logic [2:0]  CMD_RESERVED_HI = 3'd7;

    // descriptor keys and sizes: device, configuration, language, manufacturer, product
    localparam logic [15:0] DESC_VALUE [DESC_ENTRIES] =
        '{16'h0100, 16'h0200, 16'h0300, 16'h0301, 16'h0302};
    localparam logic [15:0] DESC_INDEX [DESC_ENTRIES] =
        '{16'h0000, 16'h0000, 16'h0000, 16'h0409, 16'h0409};
    localparam int DESC_SIZE [DESC_ENTRIES] = '{18, 25, 4, 32, 32};

    class ep0_scoreboard;
        result_t    awaited_results[$];
        result_t    burst[$];
        int         mismatches;
        logic       tx_bank;
        logic       tx_data1;
        logic       more_valid;
        logic [2:0] more_sel;
        logic [7:0] more_off;
        logic [7:0] more_left;
        logic       addr_pending;
        logic [6:0] new_addr;

        function new();
            mismatches   = 0;
            tx_bank      = 1'b0;
            tx_data1     = 1'b0;
            addr_pending = 1'b0;
            new_addr     = '0;
            drop_pending();
        endfunction

        function void drop_pending();
            more_valid = 1'b0;
            more_sel   = '0;
            more_off   = '0;
            more_left  = '0;
        endfunction

        function void stage(logic [2:0] kind, logic bank, logic [6:0] count, logic d1,
                            logic [2:0] sel, logic [7:0] off, logic [6:0] addr);
            result_t r;
            if (burst.size() >= 3)
                return;
            r = '{kind, bank, count, d1, sel, off, addr, 1'b0};
            burst.push_back(r);
        endfunction

        function void send_chunk(logic [2:0] sel, logic [7:0] off, logic [6:0] size);
            stage(KIND_TRANSMIT, tx_bank, size, tx_data1, sel, off, 7'd0);
            tx_bank  = ~tx_bank;
            tx_data1 = ~tx_data1;
        endfunction

        // up to two chunks now, the rest waits for in tokens
        function void queue_descriptor(logic [2:0] sel, int len);
            int offset;
            int size;
            offset = 0;
            for (int c = 0; c < 2; c++)
            begin
                size = (len > MAX_PACKET) ? MAX_PACKET : len;
                send_chunk(sel, offset[7:0], size[6:0]);
                offset += size;
                len    -= size;
                if (len == 0 && size < MAX_PACKET)
                    return;
            end
            more_valid = 1'b1;
            more_sel   = sel;
            more_off   = offset[7:0];
            more_left  = len[7:0];
        endfunction

        function void decode_setup(logic bank, logic [15:0] code, logic [15:0] value,
                                   logic [15:0] index, logic [15:0] want);
            bit found;
            int len;
            found = 0;
            stage(KIND_REARM, bank, CHUNK_BYTES, 1'b1, 3'd0, 8'd0, 7'd0);
            drop_pending();
            tx_data1     = 1'b1;
            addr_pending = (code == REQ_SET_ADDRESS);
            new_addr     = value[6:0];
            if (code == REQ_SET_ADDRESS || code == REQ_SET_CONFIG)
            begin
                queue_descriptor(3'd0, 0);
                return;
            end
            if (code == REQ_GET_DESC_DEV || code == REQ_GET_DESC_IF)
            begin
                for (int i = 0; i < DESC_ENTRIES; i++)
                begin
                    if (!found && DESC_VALUE[i] == value && DESC_INDEX[i] == index)
                    begin
                        found = 1;
                        len = (DESC_SIZE[i] > int'(want)) ? int'(want) : DESC_SIZE[i];
                        queue_descriptor(3'(i), len);
                    end
                end
            end
            if (!found)
                stage(KIND_STALL, 1'b0, 7'd0, 1'b0, 3'd0, 8'd0, 7'd0);
        endfunction

        function void serve_in();
            logic [7:0] size;
            if (more_valid)
            begin
                size = (more_left > 8'(MAX_PACKET)) ? 8'(MAX_PACKET) : more_left;
                send_chunk(more_sel, more_off, size[6:0]);
                more_off   = more_off + size;
                more_left  = more_left - size;
                more_valid = (more_left > 0) || (size == 8'(MAX_PACKET));
            end
            if (addr_pending)
                stage(KIND_SET_ADDR, 1'b0, 7'd0, 1'b0, 3'd0, 8'd0, new_addr);
        endfunction

        function void note_event(logic [2:0] cmd, logic bank, logic [15:0] code,
                                 logic [15:0] value, logic [15:0] index, logic [15:0] want);
            burst.delete();
            case (cmd)
                CMD_SETUP: decode_setup(bank, code, value, index, want);
                CMD_IN:    serve_in();
                CMD_OUT:   stage(KIND_REARM, bank, CHUNK_BYTES, 1'b1, 3'd0, 8'd0, 7'd0);
                CMD_BUS_RESET:
                begin
                    tx_bank      = 1'b0;
                    addr_pending = 1'b0;
                    drop_pending();
                    stage(KIND_REARM, 1'b0, CHUNK_BYTES, 1'b0, 3'd0, 8'd0, 7'd0);
                    stage(KIND_REARM, 1'b1, CHUNK_BYTES, 1'b0, 3'd0, 8'd0, 7'd0);
                    stage(KIND_SET_ADDR, 1'b0, 7'd0, 1'b0, 3'd0, 8'd0, 7'd0);
                end
                default: ;
            endcase
            if (burst.size() > 0)
                burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i])
                awaited_results.push_back(burst[i]);
        endfunction

        function string show(result_t r);
            return $sformatf("kind=%0d bank=%0d count=%0d d1=%0d sel=%0d off=%0d addr=%0d last=%0d",
                             r.kind, r.bank_odd, r.byte_count, r.data1,
                             r.descriptor_select, r.byte_offset, r.device_address, r.last);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result beat: %s", show(got));
                return;
            end
            exp = awaited_results.pop_front();
            if (got.kind !== exp.kind || got.bank_odd !== exp.bank_odd
                || got.byte_count !== exp.byte_count || got.data1 !== exp.data1
                || got.descriptor_select !== exp.descriptor_select
                || got.byte_offset !== exp.byte_offset
                || got.device_address !== exp.device_address || got.last !== exp.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: result mismatch at %0t", $realtime);
                    $display("  expected %s", show(exp));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    ep0_scoreboard sb;
    int            events_sent;
    bit            quiet;

    usb_control_endpoint_engine i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    // sink: check every result beat, stall in random bursts
    initial
    begin
        int      stall_left;
        result_t got;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = '{m_tuser, m_tdata[0], m_tdata[7:1], m_tdata[8], m_tdata[11:9],
                        m_tdata[19:12], m_tdata[26:20], m_tlast};
                sb.check_result(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_event(logic [2:0] cmd, logic bank, logic [15:0] code,
                              logic [15:0] value, logic [15:0] index, logic [15:0] want);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, want, index, value, code, bank};
        do @(posedge clk); while (!s_tready);
        sb.note_event(cmd, bank, code, value, index, want);
        events_sent++;
    endtask

    task automatic send_setup(logic [15:0] code, logic [15:0] value,
                              logic [15:0] index, logic [15:0] want);
        send_event(CMD_SETUP, 1'($urandom_range(0, 1)), code, value, index, want);
    endtask

    task automatic send_short(logic [2:0] cmd);
        send_event(cmd, 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
    endtask

    // setup, data stage, then status stage
    task automatic run_transfer();
        int          k;
        logic [15:0] code;
        logic [15:0] want;
        k    = $urandom_range(0, 4);
        code = $urandom_range(0, 1) ? REQ_GET_DESC_DEV : REQ_GET_DESC_IF;
        want = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        case ($urandom_range(0, 7))
            0: send_setup(REQ_SET_ADDRESS, 16'($urandom), 16'($urandom), 16'($urandom));
            1: send_setup(REQ_SET_CONFIG, 16'($urandom), 16'($urandom), 16'($urandom));
            7: send_setup(($urandom_range(0, 1) ? code : 16'($urandom)), 16'($urandom),
                          ($urandom_range(0, 1) ? LANG_EN_US : 16'($urandom)), want);
            default: send_setup(code, DESC_VALUE[k], DESC_INDEX[k], want);
        endcase
        repeat ($urandom_range(0, 3)) send_short(CMD_IN);
        if ($urandom_range(0, 1))
            send_short(CMD_OUT);
    endtask

    initial
    begin
        sb          = new();
        events_sent = 0;
        quiet       = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_SOF;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_event(CMD_IN, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_event(CMD_SETUP, 1'b0, REQ_GET_DESC_DEV, DESC_VALUE[0], DESC_INDEX[0], 16'hFFFF);
        send_event(CMD_IN, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_event(CMD_SETUP, 1'b1, REQ_GET_DESC_IF, DESC_VALUE[1], DESC_INDEX[1], 16'd9);
        send_event(CMD_SETUP, 1'b0, REQ_GET_DESC_DEV, DESC_VALUE[2], DESC_INDEX[2], 16'd0);
        send_event(CMD_SETUP, 1'b1, REQ_GET_DESC_DEV, DESC_VALUE[3], DESC_INDEX[3], 16'd64);
        send_event(CMD_SETUP, 1'b0, REQ_GET_DESC_IF, DESC_VALUE[4], DESC_INDEX[4], 16'd32);
        // right key, wrong language
        send_event(CMD_SETUP, 1'b1, REQ_GET_DESC_DEV, DESC_VALUE[3], 16'h0000, 16'd64);
        send_event(CMD_SETUP, 1'b0, REQ_GET_DESC_DEV, 16'h0400, 16'h0000, 16'd64);
        send_event(CMD_SETUP, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_event(CMD_SETUP, 1'b0, REQ_SET_CONFIG, 16'h0001, 16'h0000, 16'h0000);
        send_event(CMD_SETUP, 1'b1, REQ_SET_ADDRESS, 16'hFFFF, 16'h0000, 16'h0000);
        send_event(CMD_IN, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_event(CMD_IN, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_event(CMD_OUT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_event(CMD_OUT, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_event(CMD_SOF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_event(CMD_BUS_RESET, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_event(CMD_IN, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_event(CMD_SETUP, 1'b0, REQ_SET_ADDRESS, 16'h0005, 16'h0000, 16'h0000);
        send_event(CMD_IN, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        for (logic [3:0] c = CMD_RESERVED_LO; c <= CMD_RESERVED_HI; c++)
            send_event(c[2:0], 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_event(CMD_SETUP, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // random part: mostly whole transfers, some noise and bus events
        events_sent = 0;
        while (events_sent < RANDOM_EVENTS)
        begin
            quiet = (events_sent >= QUIET_FROM);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: run_transfer();
                6: send_short($urandom_range(0, 1) ? CMD_BUS_RESET : CMD_SOF);
                default: send_short(3'($urandom_range(0, 7)));
            endcase
        end
        s_tvalid <= 1'b0;

        while (sb.awaited_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
